/* rtl/sai_pkg.sv */
// ----------------------------------------------------------------------------
// sai_pkg: shared types and constants for the shift array block
// Array depth, request and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package sai_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W    = 6;
	localparam int WORD_W   = 32;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd2;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_CREATED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE       = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic              cap;      // capture the request fields
		logic              load;     // write next slot, emit
		logic              ins;      // insert at position, emit
		logic              match;    // register the compare vector
		logic              del;      // delete at match, emit
		logic              rd;       // emit one read-out entry
		logic              err;      // emit an error result
		logic [STAT_W-1:0] err_code;
	} sai_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             created;
		logic             pos_ok;
		logic             found;
		logic             rd_last;
	} sai_stat_t;

endpackage

/* rtl/sai_ctrl.sv */
// ----------------------------------------------------------------------------
// sai_ctrl: request sequencer
// Accepts a transaction, decodes it and steps the datapath through it.
// ----------------------------------------------------------------------------
module sai_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sai_pkg::sai_stat_t  stat,
	output sai_pkg::sai_cmd_t   cmd
);
	import sai_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DEL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (stat.req == REQ_LOAD) begin
					cmd.load = 1'b1;
				end else if (!stat.created) begin
					cmd.err      = 1'b1;
					cmd.err_code = ST_NOT_CREATED;
				end else begin
					case (stat.req)
						REQ_READ: state_d = S_READ;
						REQ_INSERT: begin
							if (stat.pos_ok) begin
								cmd.ins = 1'b1;
							end else begin
								cmd.err      = 1'b1;
								cmd.err_code = ST_RANGE;
							end
						end
						REQ_DELETE: begin
							cmd.match = 1'b1;
							state_d   = S_DEL;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				cmd.rd = 1'b1;
				if (stat.rd_last) begin
					state_d = S_IDLE;
				end
			end
			S_DEL: begin
				state_d = S_IDLE;
				if (stat.found) begin
					cmd.del = 1'b1;
				end else begin
					cmd.err      = 1'b1;
					cmd.err_code = ST_NOT_FOUND;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/sai_dp.sv */
// ----------------------------------------------------------------------------
// sai_dp: array datapath
// Word array with shift-up/shift-down, fill counter, match vector, result regs.
// ----------------------------------------------------------------------------
module sai_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sai_pkg::sai_cmd_t                 cmd,
	output sai_pkg::sai_stat_t                stat,
	input  logic [sai_pkg::REQ_W-1:0]         req_type,
	input  logic [sai_pkg::POS_W-1:0]         position,
	input  logic signed [sai_pkg::WORD_W-1:0] item_value,
	output logic                              strobe,
	output logic [sai_pkg::STAT_W-1:0]        status,
	output logic signed [sai_pkg::WORD_W-1:0] value,
	output logic [sai_pkg::POS_W-1:0]         index,
	output logic                              last
);
	import sai_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [POS_W:0]   DEPTH_P  = (POS_W + 1)'(DEPTH);

	logic [REQ_W-1:0]         req_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [WORD_W-1:0] item_q;
	logic signed [WORD_W-1:0] elem_q [DEPTH];
	logic [DEPTH-1:0]         match_q;
	logic [IDX_W-1:0]         fill_q;
	logic                     created_q;
	logic [IDX_W-1:0]         rd_idx_q;

	logic                     strobe_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [WORD_W-1:0] value_q;
	logic [POS_W-1:0]         index_q;
	logic                     last_q;

	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] found_idx;
	logic             rd_last;

	assign pos_idx = pos_q[IDX_W-1:0];
	assign rd_last = (rd_idx_q == LAST_IDX);

	// lowest set bit of the match vector
	always_comb begin
		found_idx = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (match_q[k]) begin
				found_idx = IDX_W'(k);
			end
		end
	end

	assign stat.req     = req_q;
	assign stat.created = created_q;
	assign stat.pos_ok  = ({1'b0, pos_q} < DEPTH_P);
	assign stat.found   = |match_q;
	assign stat.rd_last = rd_last;

	// request capture and match vector
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q  <= req_type;
			pos_q  <= position;
			item_q <= item_value;
		end
		if (cmd.match) begin
			for (int k = 0; k < DEPTH; k++) begin
				match_q[k] <= (elem_q[k] == item_q);
			end
		end
	end

	// word array
	always_ff @(posedge clk) begin
		for (int k = 0; k < DEPTH; k++) begin
			if (cmd.load && (fill_q == IDX_W'(k))) begin
				elem_q[k] <= item_q;
			end else if (cmd.ins) begin
				if (pos_idx == IDX_W'(k)) begin
					elem_q[k] <= item_q;
				end else if ((k > 0) && (IDX_W'(k) > pos_idx)) begin
					elem_q[k] <= elem_q[(k > 0) ? k - 1 : 0];
				end
			end else if (cmd.del && (IDX_W'(k) >= found_idx)) begin
				if (k == DEPTH - 1) begin
					// match in the top slot clears it; otherwise the top slot keeps its word
					if (found_idx == LAST_IDX) begin
						elem_q[k] <= '0;
					end
				end else begin
					elem_q[k] <= elem_q[(k < DEPTH - 1) ? k + 1 : k];
				end
			end
		end
	end

	// fill counter, created flag, read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			created_q <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			if (cmd.load) begin
				if (fill_q == LAST_IDX) begin
					fill_q    <= '0;
					created_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.rd) begin
				rd_idx_q <= rd_last ? '0 : rd_idx_q + 1'b1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.load | cmd.ins | cmd.del | cmd.rd | cmd.err;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= cmd.err ? cmd.err_code : ST_OK;
		value_q  <= cmd.rd ? elem_q[rd_idx_q] : '0;
		last_q   <= cmd.rd ? rd_last : 1'b1;
		if (cmd.load) begin
			index_q <= POS_W'(fill_q);
		end else if (cmd.ins) begin
			index_q <= pos_q;
		end else if (cmd.del) begin
			index_q <= POS_W'(found_idx);
		end else if (cmd.rd) begin
			index_q <= POS_W'(rd_idx_q);
		end else begin
			index_q <= '0;
		end
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign value  = value_q;
	assign index  = index_q;
	assign last   = last_q;

endmodule

/* rtl/shift_array_insert_delete.sv */
// ----------------------------------------------------------------------------
// shift_array_insert_delete: fixed word array with insert/delete by shifting
// Command-driven array of DEPTH signed words with load, read, insert, delete.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   req_type selects load (next slot), read (whole array), insert at
//   position, or delete of the first word equal to item_value.
//   Each result shows on status/value/index/last for one cycle with strobe
//   high; last marks the final result of a transaction. The receiver
//   cannot stall, so results are never held back.
// Timing:
//   Load, insert and any error found at decode: the result is registered
//   in the decode cycle and shows in the cycle after it.
//   Delete: the 16-way compare is registered before the
//   priority pick and the shift.
//   Read: one word per cycle from the array mux.
// Reset:
//   arst_n clears the controller, the fill counter and the created flag.
//   Array words are undefined until loaded; reads, inserts and deletes
//   report "not created" until DEPTH loads have been done.
// ----------------------------------------------------------------------------
module shift_array_insert_delete (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [sai_pkg::REQ_W-1:0]         req_type,
	input  logic [sai_pkg::POS_W-1:0]         position,
	input  logic signed [sai_pkg::WORD_W-1:0] item_value,
	output logic                              strobe,
	output logic [sai_pkg::STAT_W-1:0]        status,
	output logic signed [sai_pkg::WORD_W-1:0] value,
	output logic [sai_pkg::POS_W-1:0]         index,
	output logic                              last
);
	import sai_pkg::*;

	// command and status bundles between sequencer and datapath
	sai_cmd_t  cmd;
	sai_stat_t stat;

	// sequencer: idle -> decode -> (read sweep | delete pick) -> idle
	sai_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath: request regs, array, counters, result regs
	sai_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.position   (position),
		.item_value (item_value),
		.strobe     (strobe),
		.status     (status),
		.value      (value),
		.index      (index),
		.last       (last)
	);

endmodule

/* tb/shift_array_insert_delete_tb.sv */
// ----------------------------------------------------------------------------
// shift_array_insert_delete_tb: self-checking bench for the shift array block
// Drives load/read/insert/delete transactions with random idle bursts,
// predicts every result from a shadow copy of the array and checks each
// strobed result field by field, in order.
// ----------------------------------------------------------------------------
module shift_array_insert_delete_tb;
	import sai_pkg::*;

	// one request transaction as the driver sends it
	typedef struct {
		logic [REQ_W-1:0]         req;
		logic [POS_W-1:0]         pos;
		logic signed [WORD_W-1:0] word;
	} array_req_t;

	// one strobed result
	typedef struct {
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         index;
		logic                     last;
	} array_resp_t;

	localparam int N_RANDOM  = 92;   // random transactions after the directed part
	localparam int CALM_TAIL = 30;   // last transactions go back to back, no idling
	localparam int POOL_MAX  = 32;   // recently written words, reused as delete keys

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic [REQ_W-1:0]         req_type   = '0;
	logic [POS_W-1:0]         position   = '0;
	logic signed [WORD_W-1:0] item_value = '0;
	logic                     busy;
	logic                     strobe;
	logic [STAT_W-1:0]        status;
	logic signed [WORD_W-1:0] value;
	logic [POS_W-1:0]         index;
	logic                     last;

	shift_array_insert_delete dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.item_value (item_value),
		.strobe     (strobe),
		.status     (status),
		.value      (value),
		.index      (index),
		.last       (last)
	);

	// stimulus and scoreboard storage
	array_req_t               pending_reqs[$];    // not yet offered to the block
	array_resp_t              expected_resps[$];  // predicted, not yet seen
	logic signed [WORD_W-1:0] recent_words[$];    // keys likely to hit on delete
	array_req_t               in_flight;          // transaction currently on the pins

	// shadow copy of the block state
	logic signed [WORD_W-1:0] shadow_words[DEPTH];
	bit                       shadow_created;
	int                       shadow_fill;

	int n_total;
	int n_accepted;
	int n_results;
	int n_errors;
	int idle_left;

	// 12 time unit clock
	initial begin
		forever #6 clk = ~clk;
	end

	// reset held low from the start, released once and never asserted again
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t result %0d: %s", $time, n_results, msg);
		n_errors++;
	endtask

	// Work out the results of one accepted transaction and update the shadow
	// array the same way the block must.
	function automatic void apply_request(input array_req_t rq);
		int          hit;
		array_resp_t r;
		hit      = -1;
		r.status = ST_OK;
		r.value  = '0;
		r.index  = '0;
		r.last   = 1'b1;
		if (rq.req == REQ_LOAD) begin
			// load always goes to the fill slot, even once created
			shadow_words[shadow_fill] = rq.word;
			r.index = POS_W'(shadow_fill);
			if (shadow_fill == DEPTH - 1) begin
				// wrap; this load completes the array
				shadow_fill    = 0;
				shadow_created = 1'b1;
			end else begin
				shadow_fill++;
			end
			expected_resps.push_back(r);
		end else if (!shadow_created) begin
			// everything but a load is refused until the array is full
			r.status = ST_NOT_CREATED;
			expected_resps.push_back(r);
		end else if (rq.req == REQ_READ) begin
			for (int k = 0; k < DEPTH; k++) begin
				r.value = shadow_words[k];
				r.index = POS_W'(k);
				r.last  = (k == DEPTH - 1);
				expected_resps.push_back(r);
			end
		end else if (rq.req == REQ_INSERT) begin
			if (rq.pos >= DEPTH) begin
				r.status = ST_RANGE;
			end else begin
				// shift up from the top; the last word drops off
				for (int k = DEPTH - 2; k >= int'(rq.pos); k--)
					shadow_words[k + 1] = shadow_words[k];
				shadow_words[rq.pos] = rq.word;
				r.index = rq.pos;
			end
			expected_resps.push_back(r);
		end else begin
			// delete: first match wins
			for (int k = 0; k < DEPTH && hit < 0; k++)
				if (shadow_words[k] == rq.word)
					hit = k;
			if (hit < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				// shift down; top slot keeps its word unless the match was there
				shadow_words[hit] = '0;
				for (int k = hit; k < DEPTH - 1; k++)
					shadow_words[k] = shadow_words[k + 1];
				r.index = POS_W'(hit);
			end
			expected_resps.push_back(r);
		end
	endfunction

	task automatic queue_req(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
			input logic signed [WORD_W-1:0] word);
		array_req_t rq;
		rq.req  = req;
		rq.pos  = pos;
		rq.word = word;
		pending_reqs.push_back(rq);
		if (req == REQ_LOAD || req == REQ_INSERT) begin
			recent_words.push_back(word);
			if (recent_words.size() > POOL_MAX)
				void'(recent_words.pop_front());
		end
	endtask

	// Word mix: small values collide often (duplicates, first-match deletes),
	// extremes hit the sign and all-ones cases, the rest is full range.
	function automatic logic signed [WORD_W-1:0] random_word();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel < 2)
			return WORD_W'(int'($urandom_range(0, 8)) - 4);
		if (sel == 2) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	// Driver: offers the next transaction, holds it until busy is low at an
	// edge, and throws in idle bursts except near the end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				// transaction taken at this edge
				apply_request(in_flight);
				n_accepted++;
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
					idle_left = $urandom_range(1, 8) - 1;
					start     <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					in_flight  = pending_reqs.pop_front();
					req_type   <= in_flight.req;
					position   <= in_flight.pos;
					item_value <= in_flight.word;
					start      <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest prediction.
	always @(posedge clk) begin : resp_check
		array_resp_t want;
		if (arst_n && strobe) begin
			if (expected_resps.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d value=%0d index=%0d last=%0b",
					status, value, index, last));
			end else begin
				want = expected_resps.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (value !== want.value)
					report_mismatch($sformatf("value %0d, want %0d", value, want.value));
				if (index !== want.index)
					report_mismatch($sformatf("index %0d, want %0d", index, want.index));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
			n_results++;
		end
	end

	// Stimulus build, then wait for the queues to drain and give the verdict.
	initial begin : run_ctl
		int                       sel;
		int                       drain;
		logic signed [WORD_W-1:0] w;
		for (int k = 0; k < DEPTH; k++)
			shadow_words[k] = '0;
		shadow_created = 1'b0;
		shadow_fill    = 0;
		n_accepted     = 0;
		n_results      = 0;
		n_errors       = 0;

		// --- directed part ---
		// not created yet: read, insert and delete are all refused
		queue_req(REQ_READ, 6'd0, '0);
		queue_req(REQ_INSERT, 6'd63, 32'hffff_ffff);
		queue_req(REQ_DELETE, 6'd0, '0);
		// fill all but one slot; extremes first, then a repeated word
		for (int k = 0; k < DEPTH - 1; k++) begin
			case (k)
				0: w = 32'h8000_0000;
				1: w = 32'h7fff_ffff;
				2: w = 32'h0000_0000;
				3: w = 32'hffff_ffff;
				4, 5: w = 32'sd5;
				default: w = $urandom;
			endcase
			queue_req(REQ_LOAD, POS_W'($urandom_range(0, 63)), w);
		end
		// one slot short: still not created
		queue_req(REQ_READ, 6'd21, '0);
		// last load wraps the fill counter and creates the array
		queue_req(REQ_LOAD, 6'd63, 32'h1357_9bdf);
		queue_req(REQ_READ, 6'd0, '0);
		// insert into the top slot, then delete it: match in last slot clears it
		queue_req(REQ_INSERT, POS_W'(DEPTH - 1), 32'h2468_ace0);
		queue_req(REQ_DELETE, 6'd0, 32'h2468_ace0);
		// first position out of range
		queue_req(REQ_INSERT, POS_W'(DEPTH), 32'h0bad_0bad);
		// insert at the bottom, top word falls off
		queue_req(REQ_INSERT, 6'd0, 32'h8000_0000);
		// duplicate word: only the first match goes
		queue_req(REQ_DELETE, 6'd0, 32'sd5);
		// no match anywhere
		queue_req(REQ_DELETE, 6'd42, 32'h5555_aaaa);
		// load after creation restarts at slot 0
		queue_req(REQ_LOAD, 6'd0, 32'haaaa_5555);

		// --- random part ---
		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				queue_req(REQ_LOAD, POS_W'($urandom_range(0, 63)), random_word());
			end else if (sel < 32) begin
				queue_req(REQ_READ, POS_W'($urandom_range(0, 63)), $urandom);
			end else if (sel < 66) begin
				// mostly legal positions, some out of range
				if ($urandom_range(0, 99) < 85)
					queue_req(REQ_INSERT, POS_W'($urandom_range(0, DEPTH - 1)), random_word());
				else
					queue_req(REQ_INSERT, POS_W'($urandom_range(DEPTH, 63)), random_word());
			end else begin
				// deletes mostly aim at words that were written recently
				if (recent_words.size() > 0 && $urandom_range(0, 9) < 7)
					w = recent_words[$urandom_range(0, recent_words.size() - 1)];
				else
					w = random_word();
				queue_req(REQ_DELETE, POS_W'($urandom_range(0, 63)), w);
			end
		end
		n_total = pending_reqs.size();

		// every transaction taken, then results drained, then a read's worth of slack
		while (n_accepted < n_total)
			@(posedge clk);
		drain = 0;
		while (expected_resps.size() > 0 && drain < 4 * DEPTH) begin
			@(posedge clk);
			drain++;
		end
		repeat (DEPTH + 4) @(posedge clk);
		if (expected_resps.size() > 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_resps.size()));

		if (n_errors == 0) begin
			$display("shift_array_insert_delete_tb passed");
		end else begin
			$display("shift_array_insert_delete_tb failed");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("shift_array_insert_delete_tb failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/sai_pkg.sv
rtl/sai_ctrl.sv
rtl/sai_dp.sv
rtl/shift_array_insert_delete.sv
tb/shift_array_insert_delete_tb.sv
